// ===== hdl/chacha_pkg.sv =====
package chacha_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = 16;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(ROUNDS);
    localparam int BLOCK_BYTES   = 64;
    localparam int POS_W         = $clog2(BLOCK_BYTES) + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd6;

    // "expand 32-byte k"
    localparam logic [WORD_W-1:0] SIGMA [0:3] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    typedef struct packed {
        logic [7:0] data_in;
        logic       restart;
        logic       last_in;
    } item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       counter_wrapped;
    } result_t;

endpackage

// ===== hdl/chacha20_keystream_xor_core.sv =====
// An accepted byte's result is registered and appears in the cycle after, while the current block lasts;
// a byte that opens a new block (restart or block used up) passes S_LOAD, S_ROUND, S_FINAL and S_EMIT first.
// Block generation: 1 load + 80 steps of the four-lane quarter-round unit
// (20 rounds x 4 add/xor/rotate steps) + 1 feed-forward add + 1 emit.
// Throughput: 1 byte per cycle inside a block while the output is not stalled.
// Reset clears the configuration registers and counter and forces a fresh block on the first byte.
module chacha20_keystream_xor_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  chacha_pkg::item_t                   item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output chacha_pkg::result_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    localparam int W = chacha_pkg::WORD_W;
    localparam int N = chacha_pkg::NUM_WORDS;

    state_t                            state_reg, state_next;
    logic [chacha_pkg::CFG_DATA_W-1:0] key_reg [0:3];
    logic [chacha_pkg::CFG_DATA_W-1:0] nonce01_reg;
    logic [W-1:0]                      nonce2_reg;
    logic [chacha_pkg::CFG_DATA_W-1:0] start_reg;
    logic [W-1:0]                      st_reg [0:N-1];
    logic [W-1:0]                      st_next [0:N-1];
    logic [W-1:0]                      ctr_lo_reg, ctr_lo_next;
    logic [W-1:0]                      ctr_hi_reg, ctr_hi_next;
    logic [chacha_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                              wrap_reg, wrap_next;
    logic [chacha_pkg::RND_W-1:0]      rnd_reg, rnd_next;
    logic [1:0]                        qs_reg, qs_next;
    chacha_pkg::item_t                 hold_reg, hold_next;
    chacha_pkg::result_t               out_reg, out_next;
    logic                              out_valid_reg, out_valid_next;

    logic [W-1:0] init_w [0:N-1];
    logic [W-1:0] rnd_st [0:N-1];
    logic [3:0]   xi [0:3];
    logic [3:0]   yi [0:3];
    logic [3:0]   zi [0:3];
    logic [1:0]   ob [0:3];
    logic [1:0]   oc [0:3];
    logic [1:0]   od [0:3];
    logic [W-1:0] lane_sum [0:3];
    logic [W-1:0] lane_mix [0:3];
    logic [W-1:0] lane_rot [0:3];
    logic [W-1:0] ks_word;
    logic [7:0]   ks_byte;
    logic         out_free;
    logic         accept;

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = !((state_reg == S_IDLE) && out_free);
    assign accept       = item_valid && !item_stall;

    assign ks_word = st_reg[pos_reg[5:2]];
    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_w[i]         = chacha_pkg::SIGMA[i];
            init_w[4 + 2 * i] = key_reg[i][31:0];
            init_w[5 + 2 * i] = key_reg[i][63:32];
        end
        init_w[12] = ctr_lo_reg;
        init_w[13] = ctr_hi_reg;
        init_w[14] = nonce01_reg[63:32];
        init_w[15] = nonce2_reg;
    end

    // Four quarter-rounds side by side, one add/xor/rotate step each per cycle.
    // Odd rounds take the diagonals.
    always_comb
    begin
        rnd_st = st_reg;
        for (int l = 0; l < 4; l++)
        begin
            ob[l] = rnd_reg[0] ? 2'(l + 1) : 2'(l);
            oc[l] = rnd_reg[0] ? 2'(l + 2) : 2'(l);
            od[l] = rnd_reg[0] ? 2'(l + 3) : 2'(l);
            if (!qs_reg[0])
            begin
                xi[l] = 4'(l);
                yi[l] = {2'b01, ob[l]};
                zi[l] = {2'b11, od[l]};
            end
            else
            begin
                xi[l] = {2'b10, oc[l]};
                yi[l] = {2'b11, od[l]};
                zi[l] = {2'b01, ob[l]};
            end
            lane_sum[l] = st_reg[xi[l]] + st_reg[yi[l]];
            lane_mix[l] = st_reg[zi[l]] ^ lane_sum[l];
            case (qs_reg)
                2'd0:    lane_rot[l] = {lane_mix[l][15:0], lane_mix[l][31:16]};
                2'd1:    lane_rot[l] = {lane_mix[l][19:0], lane_mix[l][31:20]};
                2'd2:    lane_rot[l] = {lane_mix[l][23:0], lane_mix[l][31:24]};
                default: lane_rot[l] = {lane_mix[l][24:0], lane_mix[l][31:25]};
            endcase
            rnd_st[xi[l]] = lane_sum[l];
            rnd_st[zi[l]] = lane_rot[l];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        ctr_lo_next    = ctr_lo_reg;
        ctr_hi_next    = ctr_hi_reg;
        pos_next       = pos_reg;
        wrap_next      = wrap_reg;
        rnd_next       = rnd_reg;
        qs_next        = qs_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // drop the result once taken
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hold_next = item;
                    if (item.restart)
                    begin
                        ctr_lo_next = start_reg[31:0];
                        ctr_hi_next = nonce01_reg[31:0] + start_reg[63:32];
                    end
                    if (item.restart || pos_reg[chacha_pkg::POS_W-1])
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        out_next.data_out        = item.data_in ^ ks_byte;
                        out_next.last_out        = item.last_in;
                        out_next.counter_wrapped = wrap_reg;
                        out_valid_next           = 1'b1;
                        pos_next                 = pos_reg + 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                st_next    = init_w;
                rnd_next   = '0;
                qs_next    = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                st_next = rnd_st;
                qs_next = qs_reg + 1'b1;
                if (qs_reg == 2'd3)
                begin
                    if (rnd_reg == chacha_pkg::RND_W'(chacha_pkg::ROUNDS - 1))
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        rnd_next = rnd_reg + 1'b1;
                    end
                end
            end
            S_FINAL:
            begin
                for (int i = 0; i < N; i++)
                begin
                    st_next[i] = st_reg[i] + init_w[i];
                end
                // advance the block counter, carry into the nonce/counter word
                ctr_lo_next = ctr_lo_reg + 1'b1;
                wrap_next   = 1'b0;
                if (&ctr_lo_reg)
                begin
                    ctr_hi_next = ctr_hi_reg + 1'b1;
                    wrap_next   = &ctr_hi_reg;
                end
                pos_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next.data_out        = hold_reg.data_in ^ ks_byte;
                    out_next.last_out        = hold_reg.last_in;
                    out_next.counter_wrapped = wrap_reg;
                    out_valid_next           = 1'b1;
                    pos_next                 = pos_reg + 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctr_lo_reg    <= '0;
            ctr_hi_reg    <= '0;
            pos_reg       <= chacha_pkg::POS_W'(chacha_pkg::BLOCK_BYTES);
            wrap_reg      <= 1'b0;
            rnd_reg       <= '0;
            qs_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            nonce01_reg   <= '0;
            nonce2_reg    <= '0;
            start_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_lo_reg    <= ctr_lo_next;
            ctr_hi_reg    <= ctr_hi_next;
            pos_reg       <= pos_next;
            wrap_reg      <= wrap_next;
            rnd_reg       <= rnd_next;
            qs_reg        <= qs_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    chacha_pkg::CFG_KEY_01:   key_reg[0]  <= cfg_data;
                    chacha_pkg::CFG_KEY_23:   key_reg[1]  <= cfg_data;
                    chacha_pkg::CFG_KEY_45:   key_reg[2]  <= cfg_data;
                    chacha_pkg::CFG_KEY_67:   key_reg[3]  <= cfg_data;
                    chacha_pkg::CFG_NONCE_01: nonce01_reg <= cfg_data;
                    chacha_pkg::CFG_NONCE_2:  nonce2_reg  <= cfg_data[31:0];
                    chacha_pkg::CFG_START:    start_reg   <= cfg_data;
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

endmodule

// ===== hdl/chacha_chk.sv =====
module chacha_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_stall,
    input chacha_pkg::item_t                   item,
    input logic                                result_valid,
    input logic                                result_stall,
    input chacha_pkg::result_t                 result,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed under stall");

    // no result while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // a restart always regenerates the block, so input stays stalled for a while
    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.restart |=> item_stall ##1 item_stall)
        else $error("input taken during block generation");

    // configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind chacha20_keystream_xor_core chacha_chk u_chacha_chk (.*);

// ===== verif/tb.sv =====
module tb;

    localparam int CLK_HALF    = 2;
    localparam int RESET_LEN   = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int END_PAUSE   = 100;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_BYTES = 222;

    // one past the last register: writes here must be dropped
    localparam logic [chacha_pkg::CFG_IDX_W-1:0] CFG_NONE =
        chacha_pkg::CFG_IDX_W'(chacha_pkg::CFG_START + 1);
    localparam logic [chacha_pkg::CFG_IDX_W-1:0] REG_ORDER [7] = '{
        chacha_pkg::CFG_KEY_01, chacha_pkg::CFG_KEY_23, chacha_pkg::CFG_KEY_45,
        chacha_pkg::CFG_KEY_67, chacha_pkg::CFG_NONCE_01, chacha_pkg::CFG_NONCE_2,
        chacha_pkg::CFG_START
    };

    typedef enum {SET_ZERO, SET_ONES, SET_EDGE, SET_WRAP, SET_RANDOM} reg_setting_t;

    class keystream_scoreboard;
        logic [chacha_pkg::CFG_DATA_W-1:0] regs [7];
        logic [chacha_pkg::WORD_W-1:0]     ks_words [chacha_pkg::NUM_WORDS];
        logic [chacha_pkg::WORD_W-1:0]     ctr_low;
        logic [chacha_pkg::WORD_W-1:0]     nonce_ctr;
        int unsigned                       pos;
        bit                                wrapped;
        chacha_pkg::result_t               expected_bytes [$];
        int                                failures;
        int                                checked;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            foreach (ks_words[i])
                ks_words[i] = '0;
            load_counter();
            pos = chacha_pkg::BLOCK_BYTES;
            wrapped = 1'b0;
            failures = 0;
            checked = 0;
        endfunction

        function void load_counter();
            ctr_low   = regs[chacha_pkg::CFG_START][31:0];
            nonce_ctr = regs[chacha_pkg::CFG_NONCE_01][31:0] + regs[chacha_pkg::CFG_START][63:32];
        endfunction

        function void set_reg(logic [chacha_pkg::CFG_IDX_W-1:0] idx,
                              logic [chacha_pkg::CFG_DATA_W-1:0] val);
            if (idx > chacha_pkg::CFG_START)
                return;
            if (idx == chacha_pkg::CFG_NONCE_2)
                val[63:32] = '0;
            regs[idx] = val;
        endfunction

        function logic [chacha_pkg::WORD_W-1:0] rotl(logic [chacha_pkg::WORD_W-1:0] v, int s);
            return (v << s) | (v >> (chacha_pkg::WORD_W - s));
        endfunction

        function void quarter_round(int a, int b, int c, int d);
            ks_words[a] += ks_words[b]; ks_words[d] = rotl(ks_words[d] ^ ks_words[a], 16);
            ks_words[c] += ks_words[d]; ks_words[b] = rotl(ks_words[b] ^ ks_words[c], 12);
            ks_words[a] += ks_words[b]; ks_words[d] = rotl(ks_words[d] ^ ks_words[a], 8);
            ks_words[c] += ks_words[d]; ks_words[b] = rotl(ks_words[b] ^ ks_words[c], 7);
        endfunction

        function void advance_keystream_block();
            logic [chacha_pkg::WORD_W-1:0] init [chacha_pkg::NUM_WORDS];
            for (int i = 0; i < 4; i++)
                init[i] = chacha_pkg::SIGMA[i];
            for (int i = 0; i < 4; i++)
            begin
                init[4 + 2 * i] = regs[chacha_pkg::CFG_KEY_01 + i][31:0];
                init[5 + 2 * i] = regs[chacha_pkg::CFG_KEY_01 + i][63:32];
            end
            init[12] = ctr_low;
            init[13] = nonce_ctr;
            init[14] = regs[chacha_pkg::CFG_NONCE_01][63:32];
            init[15] = regs[chacha_pkg::CFG_NONCE_2][31:0];
            ks_words = init;
            for (int r = 0; r < chacha_pkg::DOUBLE_ROUNDS; r++)
            begin
                quarter_round(0, 4, 8, 12);
                quarter_round(1, 5, 9, 13);
                quarter_round(2, 6, 10, 14);
                quarter_round(3, 7, 11, 15);
                quarter_round(0, 5, 10, 15);
                quarter_round(1, 6, 11, 12);
                quarter_round(2, 7, 8, 13);
                quarter_round(3, 4, 9, 14);
            end
            for (int i = 0; i < chacha_pkg::NUM_WORDS; i++)
                ks_words[i] += init[i];
            // carry into the nonce word; flag the block that takes it round to zero
            wrapped = 1'b0;
            ctr_low += 1;
            if (ctr_low == '0)
            begin
                nonce_ctr += 1;
                if (nonce_ctr == '0)
                    wrapped = 1'b1;
            end
        endfunction

        function void note_byte(chacha_pkg::item_t it);
            chacha_pkg::result_t           want;
            logic [chacha_pkg::WORD_W-1:0] w;
            if (it.restart)
            begin
                load_counter();
                pos = chacha_pkg::BLOCK_BYTES;
            end
            if (pos >= chacha_pkg::BLOCK_BYTES)
            begin
                advance_keystream_block();
                pos = 0;
            end
            w = ks_words[pos / 4];
            want.data_out        = it.data_in ^ w[8 * (pos % 4) +: 8];
            want.last_out        = it.last_in;
            want.counter_wrapped = wrapped;
            pos++;
            expected_bytes.push_back(want);
        endfunction

        function void check_byte(chacha_pkg::result_t got);
            chacha_pkg::result_t want;
            if (expected_bytes.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected output beat: data %h last %b wrap %b",
                             got.data_out, got.last_out, got.counter_wrapped);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data_out !== want.data_out || got.last_out !== want.last_out ||
                got.counter_wrapped !== want.counter_wrapped)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("byte %0d: want data %h last %b wrap %b, got %h %b %b",
                             checked, want.data_out, want.last_out, want.counter_wrapped,
                             got.data_out, got.last_out, got.counter_wrapped);
            end
            checked++;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b1;
    logic                              item_valid = 1'b0;
    logic                              item_stall;
    chacha_pkg::item_t                 item = '0;
    logic                              result_valid;
    logic                              result_stall = 1'b0;
    chacha_pkg::result_t               result;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    keystream_scoreboard sb;
    int  idle_pct = 0;
    bit  hold_pending = 1'b0;
    int  quiet_cycles = 0;

    chacha20_keystream_xor_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_byte(item);
        if (rst_n && result_valid && !result_stall)
            sb.check_byte(result);
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_reg(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: random stall bursts, plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input bit restart, input bit last);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid      <= 1'b1;
        item.data_in    <= data;
        item.restart    <= restart;
        item.last_in    <= last;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // drop valid and wait until every expected byte is back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input reg_setting_t setting, input bit poke_unused);
        logic [chacha_pkg::CFG_DATA_W-1:0] vals [7];
        logic [chacha_pkg::WORD_W-1:0]     n0;
        n0 = $urandom;
        foreach (vals[i])
            vals[i] = {$urandom, $urandom};
        case (setting)
            SET_ZERO:
                foreach (vals[i])
                    vals[i] = '0;
            SET_ONES:
                foreach (vals[i])
                    vals[i] = '1;
            SET_EDGE:
            begin
                foreach (vals[i])
                    vals[i] = '1;
                vals[chacha_pkg::CFG_NONCE_01][31:0] = '0;
            end
            SET_WRAP:
            begin
                // nonce word 0 plus counter high is all ones: the first or second block wraps
                vals[chacha_pkg::CFG_NONCE_01][31:0] = n0;
                vals[chacha_pkg::CFG_START] =
                    {~n0, $urandom_range(0, 1) ? 32'hffffffff : 32'hfffffffe};
            end
            SET_RANDOM:
                if ($urandom_range(0, 1))
                    vals[chacha_pkg::CFG_START][31:0] = '1;
            default:
                ;
        endcase
        cfg_valid <= 1'b1;
        foreach (REG_ORDER[i])
        begin
            cfg_index <= REG_ORDER[i];
            cfg_data  <= vals[REG_ORDER[i]];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        if (poke_unused)
        begin
            cfg_index <= CFG_NONE;
            cfg_data  <= {$urandom, $urandom};
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_bytes(input int count, input int restart_per_mille);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom), $urandom_range(0, 999) < restart_per_mille,
                      $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        sb = new();
        // open reset with a falling edge so the block clears before the first clock
        #1 rst_n = 1'b0;
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: first byte must open a block without a restart
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h5a, 1'b1, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b0);
        send_byte(8'h3c, 1'b0, 1'b1);
        drain();

        // counter all ones over nonce word 0 of zero: every restart wraps
        program_regs(SET_EDGE, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h7e, 1'b0, 1'b0);
        send_byte(8'he7, 1'b0, 1'b1);
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(8'haa, 1'b0, 1'b1);
        drain();

        idle_pct = 30;
        program_regs(SET_ZERO, 1'b0);
        random_bytes(PHASE_BYTES, 20);
        drain();

        program_regs(SET_ONES, 1'b0);
        random_bytes(PHASE_BYTES, 20);
        drain();

        program_regs(SET_WRAP, 1'b1);
        hold_pending = 1'b1;
        random_bytes(PHASE_BYTES, 20);
        drain();

        idle_pct = 0;
        program_regs(SET_RANDOM, 1'b0);
        random_bytes(PHASE_BYTES, 20);
        drain();

        idle_pct = 30;
        program_regs(SET_WRAP, 1'b0);
        random_bytes(PHASE_BYTES, 120);
        drain();

        // closing stretch runs without idling
        idle_pct = 0;
        program_regs(SET_RANDOM, 1'b1);
        random_bytes(PHASE_BYTES, 20);
        drain();

        repeat (END_PAUSE) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== chacha20_keystream_xor_core.f =====
hdl/chacha_pkg.sv
hdl/chacha20_keystream_xor_core.sv
hdl/chacha_chk.sv
verif/tb.sv
